// File: rtl/core/lpi_pkg.sv
// shared types and constants for the line-plane intersection pipeline
package lpi_pkg;

  localparam int CW = 32;             // coordinate width
  localparam int FB = 16;             // fraction bits
  localparam int TW = 17;             // threshold register width
  localparam int DW = 2 * CW;         // divisor and remainder width
  localparam int NW = 2 * CW + FB + 1; // dividend width
  localparam int AW = 2 * CW + 2;     // point accumulator width

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    coord_t normal_x;
    coord_t normal_y;
    coord_t normal_z;
    coord_t plane_offset;
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } in_t;

  typedef struct packed {
    logic   hit;
    coord_t param_t;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   overflow;
  } out_t;

  // values that ride along with the division
  typedef struct packed {
    coord_t [2:0] o;
    coord_t [2:0] d;
    logic         neg;
    logic         hit;
    logic         qovf;
  } side_t;

  // one division cell's state
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] dvs;
    logic [CW-1:0] nlo;
    logic [CW-1:0] quo;
    side_t         side;
  } div_t;

endpackage

// File: rtl/core/lpi_if.sv
// request and result channels of the line-plane intersection block
interface lpi_in_if;
  logic          valid;
  logic          ready;
  lpi_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpi_out_if;
  logic          valid;
  logic          ready;
  lpi_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/line_plane_intersect.sv
// top level of the line-plane intersection pipeline
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      plane normal, offset, line origin, direction
//   out_ch   out  valid / ready      hit, param_t, point_x/y/z, overflow
//   cfg      in   cfg_we             cfg_wdata: parallel threshold
//
// one request per cycle sustained while out_ch takes every result; most of
// the pipeline is the chain of one-bit division cells (one per bit of t)
// every stage holds its request when the next one is full, so empty slots
// close up and in_ch stays ready while any slot ahead is free
// synchronous reset empties the pipeline and sets the threshold to 1
module line_plane_intersect (
  input  logic                   clk,
  input  logic                   rst,
  lpi_in_if.sink                 in_ch,
  lpi_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [lpi_pkg::TW-1:0] cfg_wdata
);

  logic [lpi_pkg::TW-1:0] thr;

  logic          cv [lpi_pkg::CW+1];
  logic          cr [lpi_pkg::CW+1];
  lpi_pkg::div_t cd [lpi_pkg::CW+1];

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= lpi_pkg::TW'(1);
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  lpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .din       (in_ch.data),
    .thr       (thr),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .dout      (cd[0])
  );

  // division chain, one cell per quotient bit
  for (genvar k = 0; k < lpi_pkg::CW; k++) begin : g_cell
    lpi_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ready  (cr[k]),
      .din       (cd[k]),
      .out_valid (cv[k+1]),
      .out_ready (cr[k+1]),
      .dout      (cd[k+1])
    );
  end

  lpi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[lpi_pkg::CW]),
    .in_ready  (cr[lpi_pkg::CW]),
    .din       (cd[lpi_pkg::CW]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dout      (out_ch.data)
  );

endmodule

// File: rtl/core/lpi_front.sv
// dot products, parallel test and dividend setup (four stages)
module lpi_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lpi_pkg::in_t           din,
  input  logic [lpi_pkg::TW-1:0] thr,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lpi_pkg::div_t          dout
);

  logic va, vb, vc, vd;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  logic signed [lpi_pkg::DW-1:0] pdn [3];
  logic signed [lpi_pkg::DW-1:0] pon [3];
  lpi_pkg::coord_t               wa;
  lpi_pkg::coord_t [2:0]         oa, da, ob, db, oc, dc;

  logic signed [lpi_pkg::DW+1:0] den;
  logic signed [lpi_pkg::DW+2:0] son;

  logic [lpi_pkg::DW-1:0] dabs;
  logic [lpi_pkg::NW-1:0] dvd;
  logic                   negc, hitc;

  logic signed [lpi_pkg::DW+1:0] den_abs;
  logic signed [lpi_pkg::DW+2:0] son_abs;
  logic [lpi_pkg::DW-1:0]        dabs_next;
  logic [lpi_pkg::DW-1:0]        dvd_hi;

  // ready chain: a stage takes new data when empty or moving on
  assign rdy_d     = !vd || out_ready;
  assign rdy_c     = !vc || rdy_d;
  assign rdy_b     = !vb || rdy_c;
  assign rdy_a     = !va || rdy_b;
  assign in_ready  = rdy_a;
  assign out_valid = vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
    end
  end

  // stage a: the six products
  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      pdn[0] <= din.dir_x * din.normal_x;
      pdn[1] <= din.dir_y * din.normal_y;
      pdn[2] <= din.dir_z * din.normal_z;
      pon[0] <= din.origin_x * din.normal_x;
      pon[1] <= din.origin_y * din.normal_y;
      pon[2] <= din.origin_z * din.normal_z;
      wa     <= din.plane_offset;
      oa     <= {din.origin_z, din.origin_y, din.origin_x};
      da     <= {din.dir_z, din.dir_y, din.dir_x};
    end
  end

  // stage b: dot product sums
  always_ff @(posedge clk) begin
    if (rdy_b && va) begin
      den <= (lpi_pkg::DW+2)'(pdn[0]) + (lpi_pkg::DW+2)'(pdn[1])
           + (lpi_pkg::DW+2)'(pdn[2]);
      son <= (lpi_pkg::DW+3)'(pon[0]) + (lpi_pkg::DW+3)'(pon[1])
           + (lpi_pkg::DW+3)'(pon[2]) + ((lpi_pkg::DW+3)'(wa) <<< lpi_pkg::FB);
      ob  <= oa;
      db  <= da;
    end
  end

  // stage c: magnitudes, parallel test, rounded dividend
  always_comb begin
    den_abs   = den[lpi_pkg::DW+1] ? -den : den;
    son_abs   = son[lpi_pkg::DW+2] ? -son : son;
    dabs_next = den_abs[lpi_pkg::DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb) begin
      dabs <= dabs_next;
      dvd  <= {1'b0, son_abs[lpi_pkg::DW-1:0], {lpi_pkg::FB{1'b0}}}
            + lpi_pkg::NW'(dabs_next >> 1);
      // num = -son, so num is negative exactly when son is positive
      negc <= (son > 0) != den[lpi_pkg::DW+1];
      hitc <= (den != 0)
           && !(dabs_next < (lpi_pkg::DW'(thr) << lpi_pkg::FB));
      oc   <= ob;
      dc   <= db;
    end
  end

  // stage d: quotient range check and division start
  assign dvd_hi = lpi_pkg::DW'(dvd[lpi_pkg::NW-1:lpi_pkg::CW]);

  always_ff @(posedge clk) begin
    if (rdy_d && vc) begin
      dout.side.qovf <= dvd_hi >= dabs;
      dout.rem       <= (dvd_hi >= dabs) ? '0 : dvd_hi;
      dout.dvs       <= dabs;
      dout.nlo       <= dvd[lpi_pkg::CW-1:0];
      dout.quo       <= '0;
      dout.side.neg  <= negc;
      dout.side.hit  <= hitc;
      dout.side.o    <= oc;
      dout.side.d    <= dc;
    end
  end

endmodule

// File: rtl/core/lpi_div_cell.sv
// one restoring division cell: produces one quotient bit per request
module lpi_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lpi_pkg::div_t din,
  output logic          out_valid,
  input  logic          out_ready,
  output lpi_pkg::div_t dout
);

  logic                   v;
  logic [lpi_pkg::DW:0]   rsh;
  logic                   ge;
  logic [lpi_pkg::DW:0]   rdif;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  // shift in the next dividend bit, subtract where it fits
  always_comb begin
    rsh  = {din.rem, din.nlo[lpi_pkg::CW-1]};
    ge   = rsh >= {1'b0, din.dvs};
    rdif = rsh - {1'b0, din.dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dout.rem  <= ge ? rdif[lpi_pkg::DW-1:0] : rsh[lpi_pkg::DW-1:0];
      dout.dvs  <= din.dvs;
      dout.nlo  <= {din.nlo[lpi_pkg::CW-2:0], 1'b0};
      dout.quo  <= {din.quo[lpi_pkg::CW-2:0], ge};
      dout.side <= din.side;
    end
  end

endmodule

// File: rtl/core/lpi_back.sv
// saturate t, form the point and hold the result (three stages)
module lpi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lpi_pkg::div_t din,
  output logic          out_valid,
  input  logic          out_ready,
  output lpi_pkg::out_t dout
);

  logic vx, vy, vz;
  logic rdy_x, rdy_y, rdy_z;

  lpi_pkg::coord_t       tx, ty;
  logic                  tovx, tovy, hitx, hity;
  lpi_pkg::coord_t [2:0] ox, dx, oy;
  logic signed [lpi_pkg::DW-1:0] prod [3];

  logic                  sat_pos, sat_neg, sat;
  lpi_pkg::coord_t       t_next;

  logic signed [lpi_pkg::AW-1:0] acc [3];
  logic signed [lpi_pkg::AW-1:0] shv [3];
  lpi_pkg::coord_t [2:0]         pnt;
  logic [2:0]                    psat;

  assign rdy_z     = !vz || out_ready;
  assign rdy_y     = !vy || rdy_z;
  assign rdy_x     = !vx || rdy_y;
  assign in_ready  = rdy_x;
  assign out_valid = vz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= 1'b0;
      vy <= 1'b0;
      vz <= 1'b0;
    end else begin
      if (rdy_x) vx <= in_valid;
      if (rdy_y) vy <= vx;
      if (rdy_z) vz <= vy;
    end
  end

  // stage x: signed, saturated t
  always_comb begin
    sat_pos = din.side.qovf || din.quo[lpi_pkg::CW-1];
    sat_neg = din.side.qovf
           || (din.quo[lpi_pkg::CW-1] && (din.quo[lpi_pkg::CW-2:0] != '0));
    sat     = din.side.neg ? sat_neg : sat_pos;
    if (!din.side.hit) begin
      t_next = '0;
    end else if (din.side.neg) begin
      t_next = sat_neg ? lpi_pkg::CMIN : -lpi_pkg::coord_t'(din.quo);
    end else begin
      t_next = sat_pos ? lpi_pkg::CMAX : lpi_pkg::coord_t'(din.quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_x && in_valid) begin
      tx   <= t_next;
      tovx <= din.side.hit && sat;
      hitx <= din.side.hit;
      ox   <= din.side.o;
      dx   <= din.side.d;
    end
  end

  // stage y: direction times t
  always_ff @(posedge clk) begin
    if (rdy_y && vx) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= dx[i] * tx;
      end
      ty   <= tx;
      tovy <= tovx;
      hity <= hitx;
      oy   <= ox;
    end
  end

  // stage z: add origin, round half up, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i]  = (lpi_pkg::AW'(oy[i]) <<< lpi_pkg::FB) + lpi_pkg::AW'(prod[i])
              + (lpi_pkg::AW'(1) <<< (lpi_pkg::FB - 1));
      shv[i]  = acc[i] >>> lpi_pkg::FB;
      psat[i] = (shv[i][lpi_pkg::AW-1:lpi_pkg::CW-1] != '0)
             && (shv[i][lpi_pkg::AW-1:lpi_pkg::CW-1] != '1);
      if (psat[i]) begin
        pnt[i] = shv[i][lpi_pkg::AW-1] ? lpi_pkg::CMIN : lpi_pkg::CMAX;
      end else begin
        pnt[i] = shv[i][lpi_pkg::CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_z && vy) begin
      dout.hit      <= hity;
      dout.param_t  <= hity ? ty : '0;
      dout.point_x  <= hity ? pnt[0] : '0;
      dout.point_y  <= hity ? pnt[1] : '0;
      dout.point_z  <= hity ? pnt[2] : '0;
      dout.overflow <= hity && (tovy || (psat != '0));
    end
  end

endmodule

// File: rtl/core/lpi_checker.sv
// port-level checks for the line-plane intersection block
module lpi_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input lpi_pkg::out_t out_data
);

  // a parallel line reports all-zero fields
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.param_t == '0 && out_data.point_x == '0
      && out_data.point_y == '0 && out_data.point_z == '0 && !out_data.overflow)
    else $error("no-hit result carries nonzero fields");

  // with the output slot empty the whole chain can move, so input is ready
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output slot");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind line_plane_intersect lpi_checker u_lpi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// File: dv/tb_line_plane_intersect.sv
// testbench for the line-plane intersection pipeline: directed and random checks
`timescale 1ns / 100ps

module tb_line_plane_intersect;

  typedef logic signed [129:0] acc_t;
  typedef logic [129:0] mag_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [lpi_pkg::TW-1:0] cfg_wdata;

  lpi_in_if  in_ch ();
  lpi_out_if out_ch ();

  line_plane_intersect i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [lpi_pkg::TW-1:0] thr_shadow;
  lpi_pkg::out_t          hits_pending[$];
  int                     src_idle_pct;
  int                     snk_idle_pct;
  bit                     snk_hold = 1'b0;
  bit                     failed;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected intersection for one request at the current threshold
  function automatic lpi_pkg::out_t predict_intersection(lpi_pkg::in_t x);
    lpi_pkg::out_t r;
    acc_t den, num, acc, rnd;
    mag_t an, ad, q;
    lpi_pkg::coord_t t, c;
    lpi_pkg::coord_t o[3], d[3];
    logic neg, ov;
    r = '0;
    o[0] = x.origin_x; o[1] = x.origin_y; o[2] = x.origin_z;
    d[0] = x.dir_x;    d[1] = x.dir_y;    d[2] = x.dir_z;
    den = acc_t'(x.dir_x) * acc_t'(x.normal_x) + acc_t'(x.dir_y) * acc_t'(x.normal_y)
        + acc_t'(x.dir_z) * acc_t'(x.normal_z);
    ad = (den < 0) ? mag_t'(-den) : mag_t'(den);
    if (den == 0 || ad < (mag_t'(thr_shadow) << lpi_pkg::FB)) return r;
    num = -(acc_t'(x.origin_x) * acc_t'(x.normal_x) + acc_t'(x.origin_y) * acc_t'(x.normal_y)
        + acc_t'(x.origin_z) * acc_t'(x.normal_z) + (acc_t'(x.plane_offset) <<< lpi_pkg::FB));
    an = (num < 0) ? mag_t'(-num) : mag_t'(num);
    neg = (num < 0) != (den < 0);
    // round to nearest, ties away from zero, on the magnitude
    q = ((an << lpi_pkg::FB) + (ad >> 1)) / ad;
    ov = 1'b0;
    if (!neg) begin
      if (q > mag_t'(lpi_pkg::CMAX)) begin ov = 1'b1; t = lpi_pkg::CMAX; end
      else t = lpi_pkg::coord_t'(q);
    end else begin
      if (q > mag_t'(lpi_pkg::CMAX) + 1) begin ov = 1'b1; t = lpi_pkg::CMIN; end
      else t = lpi_pkg::coord_t'(-q);
    end
    r.hit = 1'b1;
    r.param_t = t;
    // point from the saturated t, ties toward plus infinity
    for (int i = 0; i < 3; i++) begin
      acc = (acc_t'(o[i]) <<< lpi_pkg::FB) + acc_t'(d[i]) * acc_t'(t)
          + (acc_t'(1) <<< (lpi_pkg::FB - 1));
      rnd = acc >>> lpi_pkg::FB;
      if (rnd > acc_t'(lpi_pkg::CMAX)) begin ov = 1'b1; c = lpi_pkg::CMAX; end
      else if (rnd < acc_t'(lpi_pkg::CMIN)) begin ov = 1'b1; c = lpi_pkg::CMIN; end
      else c = lpi_pkg::coord_t'(rnd);
      if (i == 0) r.point_x = c;
      else if (i == 1) r.point_y = c;
      else r.point_z = c;
    end
    r.overflow = ov;
    return r;
  endfunction

  // result side: random stalls, long hold-off, and compare
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hits_pending.size() == 0) begin
          $error("result with no request outstanding");
          failed = 1'b1;
        end else begin
          lpi_pkg::out_t e;
          lpi_pkg::out_t a;
          e = hits_pending.pop_front();
          a = out_ch.data;
          if (a.hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, a.hit); failed = 1'b1;
          end
          if (a.param_t !== e.param_t) begin
            $error("param_t exp %0d got %0d", e.param_t, a.param_t); failed = 1'b1;
          end
          if (a.point_x !== e.point_x) begin
            $error("point_x exp %0d got %0d", e.point_x, a.point_x); failed = 1'b1;
          end
          if (a.point_y !== e.point_y) begin
            $error("point_y exp %0d got %0d", e.point_y, a.point_y); failed = 1'b1;
          end
          if (a.point_z !== e.point_z) begin
            $error("point_z exp %0d got %0d", e.point_z, a.point_z); failed = 1'b1;
          end
          if (a.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, a.overflow); failed = 1'b1;
          end
        end
      end
      if (snk_hold) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // receiver hold-off counter, run as a process of its own
  task automatic hold_receiver(int n);
    snk_hold = 1'b1;
    repeat (n) @(posedge clk);
    snk_hold = 1'b0;
  endtask

  // send one request, with optional idle cycles ahead of it
  task automatic send_query(lpi_pkg::in_t x);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= x;
    do @(posedge clk); while (!in_ch.ready);
    hits_pending.push_back(predict_intersection(x));
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_threshold(logic [lpi_pkg::TW-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_shadow = v;
  endtask

  function automatic lpi_pkg::coord_t small_coord(int span);
    return lpi_pkg::coord_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic lpi_pkg::in_t make(lpi_pkg::coord_t nx, lpi_pkg::coord_t ny,
                                        lpi_pkg::coord_t nz, lpi_pkg::coord_t w,
                                        lpi_pkg::coord_t ox, lpi_pkg::coord_t oy,
                                        lpi_pkg::coord_t oz, lpi_pkg::coord_t dx,
                                        lpi_pkg::coord_t dy, lpi_pkg::coord_t dz);
    lpi_pkg::in_t x;
    x = '{nx, ny, nz, w, ox, oy, oz, dx, dy, dz};
    return x;
  endfunction

  // random request: mostly sane geometry, some near-parallel, some near saturation, some raw bits
  function automatic lpi_pkg::in_t random_query;
    lpi_pkg::in_t x;
    int k;
    k = $urandom_range(99);
    if (k < 65) begin
      x = make(small_coord(1 << 18), small_coord(1 << 18), small_coord(1 << 18),
               small_coord(1 << 22), small_coord(1 << 22), small_coord(1 << 22),
               small_coord(1 << 22), small_coord(1 << 18), small_coord(1 << 18),
               small_coord(1 << 18));
    end else if (k < 80) begin
      // direction nearly in the plane
      x = make(small_coord(1 << 17), 32'sd0, 32'sd0, small_coord(1 << 20),
               small_coord(1 << 20), small_coord(1 << 20), small_coord(1 << 20),
               small_coord(4), small_coord(1 << 17), small_coord(1 << 17));
    end else if (k < 90) begin
      // small den, large offset: pushes t and the point to saturation
      x = make(small_coord(1 << 16), small_coord(16), small_coord(16), $urandom,
               $urandom, $urandom, $urandom, small_coord(1 << 16), small_coord(16),
               small_coord(16));
    end else begin
      x = make($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom);
    end
    return x;
  endfunction

  task automatic test_directed;
    lpi_pkg::coord_t one;
    one = 32'sh0001_0000;
    // plane z = 0, line straight down from z = 5
    send_query(make(0, 0, one, 0, one, 2 * one, 5 * one, 0, 0, -one));
    // direction in the plane: den exactly zero
    send_query(make(0, 0, one, one, 0, 0, 0, one, one, 0));
    // all zero
    send_query('0);
    // all extremes
    send_query(make(lpi_pkg::CMAX, lpi_pkg::CMAX, lpi_pkg::CMAX, lpi_pkg::CMAX,
                    lpi_pkg::CMAX, lpi_pkg::CMAX, lpi_pkg::CMAX, lpi_pkg::CMAX,
                    lpi_pkg::CMAX, lpi_pkg::CMAX));
    send_query(make(lpi_pkg::CMIN, lpi_pkg::CMIN, lpi_pkg::CMIN, lpi_pkg::CMIN,
                    lpi_pkg::CMIN, lpi_pkg::CMIN, lpi_pkg::CMIN, lpi_pkg::CMIN,
                    lpi_pkg::CMIN, lpi_pkg::CMIN));
    send_query(make(lpi_pkg::CMAX, lpi_pkg::CMIN, lpi_pkg::CMAX, lpi_pkg::CMIN,
                    lpi_pkg::CMIN, lpi_pkg::CMAX, lpi_pkg::CMIN, lpi_pkg::CMIN,
                    lpi_pkg::CMAX, lpi_pkg::CMIN));
    // den exactly one and just below one, both well above the default threshold
    send_query(make(one, 0, 0, 3 * one, 0, 0, 0, one, 0, 0));
    send_query(make(one, 0, 0, 3 * one, 0, 0, 0, 32'sh0000_ffff, 0, 0));
    // den of one, extreme offsets: large t, saturated for CMIN
    send_query(make(one, 0, 0, lpi_pkg::CMAX, 0, 0, 0, one, 0, 0));
    send_query(make(one, 0, 0, lpi_pkg::CMIN, 0, 0, 0, one, 0, 0));
    // t halfway between steps, both signs
    send_query(make(one, 0, 0, 1, 0, 0, 0, 2 * one, 0, 0));
    send_query(make(one, 0, 0, -1, 0, 0, 0, 2 * one, 0, 0));
    // origin already on the plane: numerator zero with negative den
    send_query(make(one, 0, 0, 0, 0, 7 * one, 0, -one, 0, 0));
    // point saturates while t does not
    send_query(make(one, 0, 0, -(one <<< 10), 0, 0, 0, one, lpi_pkg::CMAX, lpi_pkg::CMIN));
  endtask

  task automatic test_thresholds;
    // zero threshold: exact zero den is still parallel
    write_threshold('0);
    send_query(make(0, 0, 32'sh0001_0000, 0, 0, 0, 0, 1, 1, 0));
    send_query(make(1, 0, 0, 5, 0, 0, 0, 1, 0, 0));
    // threshold at a den of one: den just at and just below it
    write_threshold(17'd65536);
    send_query(make(32'sh0001_0000, 0, 0, 0, 0, 0, 0, 32'sh0001_0000, 0, 0));
    send_query(make(32'sh0001_0000, 0, 0, 0, 0, 0, 0, 32'sh0000_ffff, 0, 0));
    for (int i = 0; i < 20; i++) send_query(random_query());
    write_threshold(17'h1ffff);
    for (int i = 0; i < 10; i++) send_query(random_query());
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 149) write_threshold(lpi_pkg::TW'($urandom_range(65536)));
      send_query(random_query());
    end
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure;
    drain();
    src_idle_pct = 0;
    fork
      hold_receiver(300);
    join_none
    for (int i = 0; i < 120; i++) send_query(random_query());
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    thr_shadow   = 17'd1;
    src_idle_pct = 15;
    snk_idle_pct = 71;
    failed       = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_thresholds();
    test_random(450);
    write_threshold(17'd1);
    src_idle_pct = 71;
    snk_idle_pct = 15;
    test_random(400);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(350);
    test_backpressure();
    snk_idle_pct = 0;
    drain();

    if (!failed && hits_pending.size() == 0) begin
      $display("tb_line_plane_intersect: PASS");
    end else begin
      $display("tb_line_plane_intersect: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_line_plane_intersect: FAIL");
    $finish;
  end

endmodule
